// ===== hdl/rpft_pkg.sv =====
// Package for the request pool tracker: command, status and entry-state codes,
// and the command/status records between the controller and the datapath.
// No dependencies.
package rpft_pkg;

  localparam int CMD_W = 3;
  localparam int NODE_W = 16;
  localparam int THR_W = 10;
  localparam int IDX_W = 10;
  localparam int STAT_W = 2;
  localparam int CNT_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_DETACH = 3'd2,
    CMD_FREE   = 3'd3,
    CMD_FREEALL = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOMATCH  = 2'd2,
    ST_DBLFREE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ES_FREE     = 2'd0,
    ES_QUEUED   = 2'd1,
    ES_DETACHED = 2'd2
  } entry_state_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_WALK_RD,
    S_WALK_EV,
    S_FREE_PUSH,
    S_DONE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic decode;
    logic alloc;
    logic walk_rd;
    logic walk_ev;
    logic free_push;
    logic finish;
    logic out_valid;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_alloc;
    logic is_walk;
    logic is_push;
    logic is_done;
    logic walk_end;
    logic walk_hit;
    logic walk_more_push;
  } ctl_stat_t;

endpackage

// ===== hdl/rpft_ctrl.sv =====
// Controller state machine for the request pool tracker.
// Depends on rpft_pkg.
module rpft_ctrl import rpft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_fire,
  input  ctl_stat_t st,
  output ctl_cmd_t  cmd,
  output logic      in_ready
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (st.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (st.is_alloc) state_nxt = S_ALLOC;
        else if (st.is_walk) state_nxt = S_WALK_RD;
        else if (st.is_push) state_nxt = S_FREE_PUSH;
        else state_nxt = S_DONE;
      end
      S_ALLOC: state_nxt = S_DONE;
      S_WALK_RD: state_nxt = S_WALK_EV;
      S_WALK_EV: begin
        if (st.walk_end) begin
          state_nxt = st.is_push ? S_FREE_PUSH : S_DONE;
        end else if (st.walk_hit) begin
          state_nxt = st.is_push ? S_FREE_PUSH : S_DONE;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_FREE_PUSH: state_nxt = st.walk_more_push ? S_WALK_RD : S_DONE;
      S_DONE: state_nxt = S_OUT;
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      S_DECODE: cmd.decode = 1'b1;
      S_ALLOC: cmd.alloc = 1'b1;
      S_WALK_RD: cmd.walk_rd = 1'b1;
      S_WALK_EV: cmd.walk_ev = 1'b1;
      S_FREE_PUSH: cmd.free_push = 1'b1;
      S_DONE: cmd.finish = 1'b1;
      S_OUT: cmd.out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/rpft_dp.sv =====
// Datapath for the request pool tracker: entry memories, list heads and walk.
// Depends on rpft_pkg.
module rpft_dp import rpft_pkg::*; #(
  parameter int ENTRIES = 1024,
  parameter int NODE_BITS = 16,
  parameter int THREAD_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [NODE_W-1:0] in_node,
  input  logic [THR_W-1:0]  in_thread,
  input  logic [IDX_W-1:0]  in_index,
  output ctl_stat_t         st,
  output logic [IDX_W-1:0]  res_index,
  output logic [STAT_W-1:0] res_status,
  output logic [CNT_W-1:0]  res_freed
);

  localparam int AW = $clog2(ENTRIES);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);
  localparam int NB = (NODE_BITS < NODE_W) ? NODE_BITS : NODE_W;
  localparam int TB = (THREAD_BITS < THR_W) ? THREAD_BITS : THR_W;

  logic [LW-1:0]        link_mem [ENTRIES];
  logic [NB-1:0]        node_mem [ENTRIES];
  logic [TB-1:0]        own_mem  [ENTRIES];
  logic [1:0]           stat_mem [ENTRIES];

  logic [LW-1:0] free_head_r, used_head_r, used_tail_r;
  logic [LW-1:0] clr_r;
  logic [CMD_W-1:0] cmd_r;
  logic [NB-1:0] node_r;
  logic [TB-1:0] thr_r;
  logic [IDX_W-1:0] idx_r;
  logic [LW-1:0] prev_r, cur_r, tgt_r;
  logic [LW-1:0] steps_r;
  logic [1:0] tgt_st_r;
  logic [LW-1:0] rd_link_r;
  logic [NB-1:0] rd_node_r;
  logic [TB-1:0] rd_own_r;
  logic [IDX_W-1:0] res_index_r;
  logic [STAT_W-1:0] res_status_r;
  logic [CNT_W-1:0] res_freed_r;
  logic [LW-1:0] fh_link_r;

  logic idx_ok;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] cur_a;
  logic walk_done;
  logic hit;
  logic link_we;
  logic [AW-1:0] link_wa;
  logic [LW-1:0] link_wd;
  logic stat_we;
  logic [AW-1:0] stat_wa;
  logic [1:0] stat_wd;

  assign idx_ok = (int'(idx_r) < ENTRIES);
  assign idx_a = AW'(idx_r);
  assign cur_a = cur_r[AW-1:0];
  assign walk_done = (cur_r >= NIL) || (steps_r >= NIL);
  assign hit = (cmd_r == CMD_LOOKUP) ? (rd_node_r == node_r) :
               (cmd_r == CMD_FREEALL) ? (rd_own_r == thr_r) :
               (cur_r == tgt_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_st_r <= stat_mem[AW'(in_index)];
    end
    if (cmd.walk_rd) begin
      rd_link_r <= link_mem[cur_a];
      rd_node_r <= node_mem[cur_a];
      rd_own_r  <= own_mem[cur_a];
    end
    if (cmd.decode) begin
      fh_link_r <= link_mem[free_head_r[AW-1:0]];
    end
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = '0;
    link_wd = '0;
    stat_we = 1'b0;
    stat_wa = '0;
    stat_wd = ES_FREE;
    if (cmd.clear_step) begin
      link_we = 1'b1;
      link_wa = clr_r[AW-1:0];
      link_wd = (clr_r == '0) ? NIL : clr_r - 1'b1;
      stat_we = 1'b1;
      stat_wa = clr_r[AW-1:0];
    end else if (cmd.alloc) begin
      link_we = 1'b1;
      link_wa = free_head_r[AW-1:0];
      link_wd = NIL;
    end else if (cmd.walk_ev && !walk_done && hit &&
                 (cmd_r == CMD_DETACH || cmd_r == CMD_FREE || cmd_r == CMD_FREEALL) &&
                 prev_r != NIL) begin
      link_we = 1'b1;
      link_wa = prev_r[AW-1:0];
      link_wd = rd_link_r;
    end else if (cmd.free_push) begin
      link_we = 1'b1;
      link_wa = tgt_r[AW-1:0];
      link_wd = free_head_r;
      stat_we = 1'b1;
      stat_wa = tgt_r[AW-1:0];
    end else if (cmd.finish && cmd_r == CMD_ALLOC && res_status_r == ST_OK &&
                 prev_r != NIL) begin
      link_we = 1'b1;
      link_wa = prev_r[AW-1:0];
      link_wd = cur_r;
    end
    if (cmd.alloc) begin
      stat_we = 1'b1;
      stat_wa = free_head_r[AW-1:0];
      stat_wd = ES_QUEUED;
    end else if (cmd.finish && cmd_r == CMD_DETACH && res_status_r == ST_OK) begin
      stat_we = 1'b1;
      stat_wa = idx_a;
      stat_wd = ES_DETACHED;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (stat_we) stat_mem[stat_wa] <= stat_wd;
    if (cmd.alloc) begin
      node_mem[free_head_r[AW-1:0]] <= node_r;
      own_mem[free_head_r[AW-1:0]]  <= thr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      free_head_r <= LW'(ENTRIES - 1);
      used_head_r <= NIL;
      used_tail_r <= NIL;
    end else begin
      if (cmd.clear_step) clr_r <= clr_r + 1'b1;
      if (cmd.alloc) begin
        free_head_r <= fh_link_r;
        used_tail_r <= free_head_r;
        if (used_tail_r >= NIL) used_head_r <= free_head_r;
      end
      if (cmd.walk_ev && !walk_done && hit && cmd_r != CMD_LOOKUP) begin
        if (prev_r == NIL) used_head_r <= rd_link_r;
        if (used_tail_r == cur_r) used_tail_r <= prev_r;
      end
      if (cmd.free_push) free_head_r <= tgt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      node_r <= in_node[NB-1:0];
      thr_r  <= in_thread[TB-1:0];
      idx_r  <= in_index;
    end
    if (cmd.decode) begin
      prev_r <= NIL;
      cur_r <= used_head_r;
      steps_r <= '0;
      tgt_r <= LW'(idx_r);
      res_index_r <= '0;
      res_freed_r <= '0;
      if (!st.is_done) res_status_r <= ST_OK;
      else if (cmd_r == CMD_ALLOC) res_status_r <= ST_FULL;
      else if (cmd_r == CMD_FREE && idx_ok && tgt_st_r == ES_FREE)
        res_status_r <= ST_DBLFREE;
      else res_status_r <= ST_NOMATCH;
    end
    // hold old tail and new entry for the tail link write
    if (cmd.alloc) begin
      res_index_r <= IDX_W'(free_head_r);
      prev_r <= used_tail_r;
      cur_r <= free_head_r;
    end
    if (cmd.walk_ev) begin
      if (!walk_done) begin
        steps_r <= steps_r + 1'b1;
        if (hit) begin
          case (cmd_r)
            CMD_LOOKUP: res_index_r <= IDX_W'(cur_r);
            CMD_FREEALL: begin
              tgt_r <= cur_r;
              cur_r <= rd_link_r;
              res_freed_r <= res_freed_r + 1'b1;
            end
            default: cur_r <= rd_link_r;
          endcase
        end else begin
          prev_r <= cur_r;
          cur_r <= rd_link_r;
        end
      end
    end
    if (cmd.walk_ev && walk_done && cmd_r == CMD_LOOKUP) res_status_r <= ST_NOMATCH;
  end

  always_comb begin
    st = '0;
    st.clear_done = (clr_r == LW'(ENTRIES - 1));
    st.is_alloc = (cmd_r == CMD_ALLOC) && (free_head_r < NIL);
    st.is_walk = (cmd_r == CMD_LOOKUP) || (cmd_r == CMD_FREEALL) ||
                 (((cmd_r == CMD_DETACH) || (cmd_r == CMD_FREE)) && idx_ok &&
                  (tgt_st_r == ES_QUEUED));
    st.is_push = ((cmd_r == CMD_FREE) && idx_ok && (tgt_st_r == ES_DETACHED)) ||
                 ((cmd_r == CMD_FREE || cmd_r == CMD_FREEALL) && cmd.walk_ev) ||
                 (cmd_r == CMD_FREEALL && cmd.free_push);
    if (cmd.walk_ev || cmd.free_push) begin
      st.is_push = (cmd_r == CMD_FREE) || (cmd_r == CMD_FREEALL);
    end
    st.is_done = !st.is_alloc && !st.is_walk && !st.is_push;
    st.walk_end = walk_done;
    st.walk_hit = hit;
    st.walk_more_push = (cmd_r == CMD_FREEALL) && (cur_r < NIL) && (steps_r < NIL);
    if (cmd.walk_ev && walk_done && cmd_r == CMD_FREE) st.is_push = 1'b0;
    if (cmd.walk_ev && walk_done && cmd_r == CMD_FREEALL) st.is_push = 1'b0;
    if (cmd.walk_ev && walk_done && cmd_r == CMD_DETACH) st.is_push = 1'b0;
  end

  assign res_index = res_index_r;
  assign res_status = res_status_r;
  assign res_freed = res_freed_r;

endmodule

// ===== hdl/request_pool_fifo_tracker_unit.sv =====
// Request pool tracker: a pool of ENTRIES request entries on a LIFO free list
// and a FIFO used list. After reset a clearing pass over every entry runs
// with in_tready low. One command is in flight at a time: in_tready is high
// only while the unit is idle, and the result is held on the out_ channel
// until taken. Allocate and detached-entry free go from decode through an
// allocate or free-list push step and a done step; a command settled at
// decode (full pool, double free, entry not queued, unknown code) goes to
// done. Lookup, detach, queued-entry free and free-all walk the used list
// with a memory read, then a compare, per entry visited, a last read and compare
// at the end of the list, and a free-list push per entry returned, so time
// grows with occupancy. in_tready is high the cycle after the result leaves.
// Depends on rpft_pkg, rpft_ctrl and rpft_dp.
module request_pool_fifo_tracker_unit import rpft_pkg::*; #(
  parameter int ENTRIES = 1024,
  parameter int NODE_BITS = 16,
  parameter int THREAD_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[2:0], node_id[18:3], thread_id[28:19], entry_index[38:29]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // result_index[9:0], status[11:10], freed_count[22:12]
);

  ctl_cmd_t  cmd;
  ctl_stat_t st;
  logic in_fire, out_fire;
  logic [IDX_W-1:0] res_index;
  logic [STAT_W-1:0] res_status;
  logic [CNT_W-1:0] res_freed;

  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  rpft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_fire (out_fire),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  rpft_dp #(
    .ENTRIES     (ENTRIES),
    .NODE_BITS   (NODE_BITS),
    .THREAD_BITS (THREAD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_cmd     (in_tdata[2:0]),
    .in_node    (in_tdata[18:3]),
    .in_thread  (in_tdata[28:19]),
    .in_index   (in_tdata[38:29]),
    .st         (st),
    .res_index  (res_index),
    .res_status (res_status),
    .res_freed  (res_freed)
  );

  assign out_tvalid = cmd.out_valid;
  assign out_tdata = {1'b0, res_freed, res_status, res_index};

endmodule

// ===== tb/testbench.sv =====
// Testbench for request_pool_fifo_tracker_unit: drives command beats, predicts each
// result with a behavioral pool model inside a small scoreboard class, checks every beat.
// Depends on rpft_pkg and the block's RTL.
`timescale 1ns / 1ps

class pool_scoreboard;
  localparam int N = 1024;
  localparam int NIL = N;
  int unsigned nxt[N];
  bit [15:0] node[N];
  bit [9:0] owner[N];
  rpft_pkg::entry_state_t est[N];
  int unsigned free_head, used_head, used_tail;
  bit [23:0] pending[$];
  int errors;
  int checked;

  function new();
    for (int i = 0; i < N; i++) begin
      nxt[i] = (i == 0) ? NIL : i - 1;
      node[i] = '0;
      owner[i] = '0;
      est[i] = rpft_pkg::ES_FREE;
    end
    free_head = N - 1;
    used_head = NIL;
    used_tail = NIL;
    errors = 0;
    checked = 0;
  endfunction

  function void unlink(int unsigned idx);
    int unsigned prev, cur, steps;
    prev = NIL;
    cur = used_head;
    steps = 0;
    while (cur < N && steps < N) begin
      if (cur == idx) begin
        if (prev == NIL) used_head = nxt[cur];
        else nxt[prev] = nxt[cur];
        if (used_tail == cur) used_tail = prev;
        nxt[cur] = NIL;
        return;
      end
      prev = cur;
      cur = nxt[cur];
      steps++;
    end
  endfunction

  function void push_free(int unsigned idx);
    nxt[idx] = free_head;
    free_head = idx;
    est[idx] = rpft_pkg::ES_FREE;
  endfunction

  function void note_command(bit [39:0] beat);
    bit [2:0] cmd;
    bit [15:0] nd;
    bit [9:0] thr;
    int unsigned idx, res, freed, e, cur, prev, steps, nx;
    rpft_pkg::status_t st;
    cmd = beat[2:0];
    nd = beat[18:3];
    thr = beat[28:19];
    idx = beat[38:29];
    res = 0;
    freed = 0;
    st = rpft_pkg::ST_OK;
    case (cmd)
      rpft_pkg::CMD_ALLOC: begin
        if (free_head >= N) begin
          st = rpft_pkg::ST_FULL;
        end else begin
          e = free_head;
          free_head = nxt[e];
          node[e] = nd;
          owner[e] = thr;
          est[e] = rpft_pkg::ES_QUEUED;
          nxt[e] = NIL;
          if (used_tail >= N) used_head = e;
          else nxt[used_tail] = e;
          used_tail = e;
          res = e;
        end
      end
      rpft_pkg::CMD_LOOKUP: begin
        st = rpft_pkg::ST_NOMATCH;
        cur = used_head;
        steps = 0;
        while (cur < N && steps < N) begin
          if (node[cur] == nd) begin
            res = cur;
            st = rpft_pkg::ST_OK;
            break;
          end
          cur = nxt[cur];
          steps++;
        end
      end
      rpft_pkg::CMD_DETACH: begin
        if (idx < N && est[idx] == rpft_pkg::ES_QUEUED) begin
          unlink(idx);
          est[idx] = rpft_pkg::ES_DETACHED;
        end else begin
          st = rpft_pkg::ST_NOMATCH;
        end
      end
      rpft_pkg::CMD_FREE: begin
        if (idx >= N) st = rpft_pkg::ST_NOMATCH;
        else if (est[idx] == rpft_pkg::ES_FREE) st = rpft_pkg::ST_DBLFREE;
        else begin
          if (est[idx] == rpft_pkg::ES_QUEUED) unlink(idx);
          push_free(idx);
        end
      end
      rpft_pkg::CMD_FREEALL: begin
        prev = NIL;
        cur = used_head;
        steps = 0;
        while (cur < N && steps < N) begin
          nx = nxt[cur];
          if (owner[cur] == thr) begin
            if (prev == NIL) used_head = nx;
            else nxt[prev] = nx;
            if (used_tail == cur) used_tail = prev;
            push_free(cur);
            freed++;
          end else begin
            prev = cur;
          end
          cur = nx;
          steps++;
        end
      end
      default: st = rpft_pkg::ST_NOMATCH;
    endcase
    pending.push_back({1'b0, freed[10:0], st, res[9:0]});
  endfunction

  function void check_result(bit [23:0] got);
    bit [23:0] exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    checked++;
    if (got[9:0] !== exp[9:0]) begin
      $display("%0t: result_index expected %0d actual %0d", $time, exp[9:0], got[9:0]);
      errors++;
    end
    if (got[11:10] !== exp[11:10]) begin
      $display("%0t: status expected %0d actual %0d", $time, exp[11:10], got[11:10]);
      errors++;
    end
    if (got[22:12] !== exp[22:12]) begin
      $display("%0t: freed_count expected %0d actual %0d", $time, exp[22:12], got[22:12]);
      errors++;
    end
  endfunction

  function int unsigned queued_pick();
    int unsigned c, k;
    c = used_head;
    k = $urandom_range(0, 7);
    while (k > 0 && c < N && nxt[c] < N) begin
      c = nxt[c];
      k--;
    end
    return (c < N) ? c : $urandom_range(0, 1023);
  endfunction
endclass

module testbench;
  import rpft_pkg::*;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [39:0] in_tdata;   // cmd, node_id, thread_id, entry_index
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;  // result_index, status, freed_count

  pool_scoreboard sb;
  int sent;
  bit hold_off;

  request_pool_fifo_tracker_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cmd(bit [2:0] cmd, bit [15:0] nd, bit [9:0] thr, bit [9:0] idx,
                          bit [39:39] pad = 1'b0);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pad, idx, thr, nd, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command({1'b0, idx, thr, nd, cmd});
    sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned g;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic random_cmd(bit [9:0] thr_pool);
    int unsigned r;
    bit [15:0] nd;
    bit [9:0] thr;
    bit [9:0] idx;
    bit [2:0] cmd;
    r = $urandom_range(0, 99);
    nd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    thr = ($urandom_range(0, 3) == 0) ? 10'($urandom) : thr_pool + 10'($urandom_range(0, 3));
    idx = ($urandom_range(0, 2) == 0) ? 10'($urandom) : 10'(sb.queued_pick());
    if (r < 45) cmd = CMD_ALLOC;
    else if (r < 60) cmd = CMD_LOOKUP;
    else if (r < 70) cmd = CMD_DETACH;
    else if (r < 88) cmd = CMD_FREE;
    else if (r < 96) cmd = CMD_FREEALL;
    else cmd = 3'($urandom_range(5, 7));
    send_cmd(cmd, nd, thr, idx);
  endtask

  initial begin
    int unsigned wait_cycles;
    sb = new();
    sent = 0;
    hold_off = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command, each corner
    send_cmd(CMD_LOOKUP, 16'h0000, 10'd0, 10'd0);
    send_cmd(CMD_FREE, 16'h0, 10'd0, 10'd0);
    send_cmd(CMD_DETACH, 16'h0, 10'd0, 10'd1023);
    send_cmd(CMD_ALLOC, 16'hFFFF, 10'd1023, 10'd0);
    send_cmd(CMD_ALLOC, 16'h0000, 10'd0, 10'h3FF);
    send_cmd(CMD_ALLOC, 16'hFFFF, 10'd5, 10'd0);
    send_cmd(CMD_LOOKUP, 16'hFFFF, 10'd0, 10'd0);
    send_cmd(CMD_LOOKUP, 16'h1234, 10'h3FF, 10'h3FF);
    send_cmd(CMD_DETACH, 16'h0, 10'd0, 10'd1022);
    send_cmd(CMD_DETACH, 16'h0, 10'd0, 10'd1022);
    send_cmd(CMD_FREE, 16'h0, 10'd0, 10'd1022);
    send_cmd(CMD_FREE, 16'h0, 10'd0, 10'd1022);
    send_cmd(CMD_FREE, 16'h0, 10'd0, 10'd1023);
    send_cmd(CMD_FREEALL, 16'h0, 10'd5, 10'd0);
    send_cmd(CMD_FREEALL, 16'h0, 10'd777, 10'd0);
    send_cmd(3'd5, 16'hFFFF, 10'h3FF, 10'h3FF);
    send_cmd(3'd7, 16'h0, 10'd0, 10'd0);

    // long receiver hold-off while the sender keeps going
    hold_off = 1'b1;
    for (int i = 0; i < 433; i++)
      random_cmd(10'($urandom_range(0, 1) ? 0 : 1020));
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 2000000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    $display("Sent %0d commands, checked %0d results: allocate, lookup hit and miss,",
             sent, sb.checked);
    $display("detach, double free, free-all and unknown codes under random output stalls.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
